// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while the reset is asserted
`define FXD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Clocked assertion that also holds during reset
`define FXD_ASSERT_NR(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("assertion failed");

`endif

// ===== rtl/fxd_pkg.sv =====
// Types and constants of the framed XOR stream decrypter.
// No dependencies; used by the modules and the checker.
package fxd_pkg;

	localparam int KEY_BYTES    = 16;
	localparam int ACCESS_BYTES = 8;
	localparam int KEY_IDX_W    = $clog2(KEY_BYTES);
	localparam int ACC_IDX_W    = $clog2(ACCESS_BYTES);

	localparam logic [7:0]  START_BYTE  = 8'hAA;
	localparam logic [7:0]  END_BYTE    = 8'h55;
	localparam logic [7:0]  KEY_SALT    = 8'h5A;
	localparam logic [15:0] RESET_LIMIT = 16'd10240;

	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_TIMEOUT = 1'b1;

	localparam logic [2:0] KIND_PLAIN   = 3'd0;
	localparam logic [2:0] KIND_GOOD    = 3'd1;
	localparam logic [2:0] KIND_REJECT  = 3'd2;
	localparam logic [2:0] KIND_BADEND  = 3'd3;
	localparam logic [2:0] KIND_TIMEOUT = 3'd4;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ACCESS,
		PH_STAMP,
		PH_SIZE,
		PH_DATA,
		PH_END
	} phase_t;

	typedef logic [ACCESS_BYTES-1:0][7:0] acc_bytes_t;
	typedef logic [3:0][7:0]              word_bytes_t;

	// Control from the frame sequencer to the keystream store
	typedef struct packed {
		logic                 commit;
		logic                 load;
		logic                 rekey;
		logic [KEY_IDX_W-1:0] idx;
		logic [7:0]           idx_byte;
	} ks_cmd_t;

endpackage

// ===== rtl/fxd_stream_if.sv =====
// Request and result channel interfaces of the framed XOR stream decrypter.
// Depends on nothing but plain logic types.
interface fxd_rx_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface fxd_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [7:0]  plain_byte;
	logic [15:0] byte_count;

	modport source (output valid, output result_kind, output plain_byte,
		output byte_count, input ready);
	modport sink   (input valid, input result_kind, input plain_byte,
		input byte_count, output ready);
endinterface

// ===== rtl/fxd_keystream.sv =====
// Derived key and rolling keystream store of the decrypter.
// Depends on fxd_pkg.
module fxd_keystream (
	input  logic                clk,
	input  fxd_pkg::ks_cmd_t    cmd,
	input  fxd_pkg::acc_bytes_t acc_bytes,
	input  logic [31:0]         timestamp,
	output logic [7:0]          ks_byte
);

	logic [fxd_pkg::KEY_BYTES-1:0][7:0] dk_q;
	logic [fxd_pkg::KEY_BYTES-1:0][7:0] ks_q;
	logic [fxd_pkg::KEY_BYTES-1:0][7:0] dk_init;

	always_comb begin
		for (int i = 0; i < fxd_pkg::KEY_BYTES; i++) begin
			dk_init[i] = acc_bytes[i % fxd_pkg::ACCESS_BYTES] ^ timestamp[i +: 8]
				^ fxd_pkg::KEY_SALT;
		end
	end

	// On a rekey the selected entry is index zero; fold in the update here too
	assign ks_byte = ks_q[cmd.idx] ^ (cmd.rekey ? (dk_q[cmd.idx] ^ cmd.idx_byte) : 8'h00);

	always_ff @(posedge clk) begin
		if (cmd.commit && cmd.load) begin
			dk_q <= dk_init;
			ks_q <= dk_init;
		end else if (cmd.commit && cmd.rekey) begin
			for (int i = 0; i < fxd_pkg::KEY_BYTES; i++) begin
				ks_q[i] <= ks_q[i] ^ dk_q[i] ^ cmd.idx_byte;
			end
		end
	end

endmodule

// ===== rtl/framed_xor_stream_decrypter.sv =====
// Framed XOR stream decrypter: frame sequencer, input and result registers.
// Depends on fxd_pkg, fxd_stream_if and fxd_keystream.
//
// Usage:
//  rx carries requests: action 0 with a received byte, action 1 for a receive
//  timeout. A frame is 0xAA, eight access key bytes, a little-endian 32-bit
//  timestamp, a little-endian 32-bit size, the payload, then 0x55.
//  res carries results: one plaintext byte per payload byte (kind 0, with its
//  index), and one status at the frame end (good, size rejected, bad end byte
//  or timeout abort). Plaintext leaves before the end check; drop any frame
//  whose status is not good. Most requests give no result.
//  Path: a request is taken into the input register and worked on there; its
//  result enters the result register when the request advances, which needs
//  the result register empty or being read; res.valid then rises if it has one.
//  Throughput: one request per cycle while results are taken, set by the
//  single-pass sequencer between the input and result registers.
//  Stall: while res.ready is low a waiting result holds and the input register
//  fills; rx.ready then drops until the result is taken.
//  Reset: both registers empty, hunting for the start byte, limit 10240.
//  Write cfg_wdata with cfg_we only while the block is idle.
module framed_xor_stream_decrypter (
	input  logic        clk,
	input  logic        arst_n,
	fxd_rx_if.sink      rx,
	fxd_res_if.source   res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic        s1_valid;
	logic        s1_action;
	logic [7:0]  s1_byte;
	logic        adv;

	logic [15:0] max_q;
	fxd_pkg::phase_t phase_q, phase_d;
	logic [2:0]  cnt_q, cnt_d;
	fxd_pkg::acc_bytes_t ak_q;
	fxd_pkg::word_bytes_t ts_q, size_q;
	logic [15:0] idx_q, idx_d;

	logic        ak_we, ts_we, size_we, clear_fields;
	logic [31:0] size_full;
	logic [16:0] idx_next;

	logic        emit;
	logic [2:0]  kind_c;
	logic [7:0]  plain_c;
	logic [15:0] count_c;

	logic        res_valid_q;
	logic [2:0]  res_kind_q;
	logic [7:0]  res_plain_q;
	logic [15:0] res_count_q;

	fxd_pkg::ks_cmd_t ks_cmd;
	logic [7:0]  ks_byte;

	assign adv      = s1_valid && (!res_valid_q || res.ready);
	assign rx.ready = !s1_valid || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (rx.ready) begin
			s1_valid <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			s1_action <= rx.action;
			s1_byte   <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= fxd_pkg::RESET_LIMIT;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	assign size_full = {s1_byte, size_q[2], size_q[1], size_q[0]};
	assign idx_next  = {1'b0, idx_q} + 17'd1;

	always_comb begin
		phase_d      = phase_q;
		cnt_d        = cnt_q;
		idx_d        = idx_q;
		ak_we        = 1'b0;
		ts_we        = 1'b0;
		size_we      = 1'b0;
		clear_fields = 1'b0;
		emit         = 1'b0;
		kind_c       = fxd_pkg::KIND_PLAIN;
		plain_c      = 8'h00;
		count_c      = idx_q;
		ks_cmd.commit   = adv;
		ks_cmd.load     = 1'b0;
		ks_cmd.rekey    = 1'b0;
		ks_cmd.idx      = idx_q[fxd_pkg::KEY_IDX_W-1:0];
		ks_cmd.idx_byte = idx_q[7:0];

		if (s1_action == fxd_pkg::ACT_TIMEOUT) begin
			if (phase_q != fxd_pkg::PH_HUNT) begin
				phase_d = fxd_pkg::PH_HUNT;
				cnt_d   = 3'd0;
				emit    = 1'b1;
				kind_c  = fxd_pkg::KIND_TIMEOUT;
			end
		end else begin
			unique case (phase_q)
				fxd_pkg::PH_HUNT: begin
					if (s1_byte == fxd_pkg::START_BYTE) begin
						phase_d      = fxd_pkg::PH_ACCESS;
						cnt_d        = 3'd0;
						idx_d        = 16'd0;
						clear_fields = 1'b1;
					end
				end
				fxd_pkg::PH_ACCESS: begin
					ak_we = 1'b1;
					cnt_d = cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						phase_d = fxd_pkg::PH_STAMP;
					end
				end
				fxd_pkg::PH_STAMP: begin
					ts_we = 1'b1;
					cnt_d = cnt_q + 3'd1;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_d   = 3'd0;
						phase_d = fxd_pkg::PH_SIZE;
					end
				end
				fxd_pkg::PH_SIZE: begin
					size_we = 1'b1;
					cnt_d   = cnt_q + 3'd1;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_d = 3'd0;
						if (size_full == 32'd0 || size_full > {16'd0, max_q}) begin
							phase_d = fxd_pkg::PH_HUNT;
							emit    = 1'b1;
							kind_c  = fxd_pkg::KIND_REJECT;
							count_c = 16'd0;
						end else begin
							ks_cmd.load = 1'b1;
							idx_d       = 16'd0;
							phase_d     = fxd_pkg::PH_DATA;
						end
					end
				end
				fxd_pkg::PH_DATA: begin
					ks_cmd.rekey = (idx_q[fxd_pkg::KEY_IDX_W-1:0] == '0) && (idx_q != 16'd0);
					plain_c      = s1_byte ^ ks_byte;
					emit         = 1'b1;
					idx_d        = idx_next[15:0];
					if (idx_next >= {1'b0, size_q[1], size_q[0]}) begin
						phase_d = fxd_pkg::PH_END;
					end
				end
				fxd_pkg::PH_END: begin
					phase_d = fxd_pkg::PH_HUNT;
					emit    = 1'b1;
					kind_c  = (s1_byte == fxd_pkg::END_BYTE) ? fxd_pkg::KIND_GOOD
						: fxd_pkg::KIND_BADEND;
				end
				default: begin
					phase_d = fxd_pkg::PH_HUNT;
					cnt_d   = 3'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fxd_pkg::PH_HUNT;
			cnt_q   <= 3'd0;
			idx_q   <= 16'd0;
			ts_q    <= '0;
			size_q  <= '0;
		end else if (adv) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			if (clear_fields) begin
				ts_q   <= '0;
				size_q <= '0;
			end
			if (ts_we) begin
				ts_q[cnt_q[1:0]] <= s1_byte;
			end
			if (size_we) begin
				size_q[cnt_q[1:0]] <= s1_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ak_we) begin
			ak_q[cnt_q[fxd_pkg::ACC_IDX_W-1:0]] <= s1_byte;
		end
	end

	fxd_keystream u_keystream (
		.clk       (clk),
		.cmd       (ks_cmd),
		.acc_bytes (ak_q),
		.timestamp (ts_q),
		.ks_byte   (ks_byte)
	);

	// Hold the result until taken; refill straight away when it leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= emit;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_kind_q  <= kind_c;
			res_plain_q <= plain_c;
			res_count_q <= count_c;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.result_kind = res_kind_q;
	assign res.plain_byte  = res_plain_q;
	assign res.byte_count  = res_count_q;

endmodule

// ===== rtl/fxd_checker.sv =====
// Port-level checks on the result channel of the decrypter, bound to the top.
// Depends on fxd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fxd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [2:0]  res_kind,
	input logic [7:0]  res_plain,
	input logic [15:0] res_count
);

	logic        acc;
	logic        prev_valid_q;
	logic [2:0]  prev_kind_q;
	logic [15:0] prev_count_q;

	assign acc = res_valid && res_ready;

	// Remember the last result taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			prev_kind_q  <= fxd_pkg::KIND_PLAIN;
			prev_count_q <= 16'd0;
		end else if (acc) begin
			prev_valid_q <= 1'b1;
			prev_kind_q  <= res_kind;
			prev_count_q <= res_count;
		end
	end

	`FXD_ASSERT_NR(a_reset_quiet, clk, !arst_n |-> !res_valid)
	`FXD_ASSERT(a_stall_hold, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_plain) && $stable(res_count))
	`FXD_ASSERT(a_plain_in_order, clk, arst_n, acc && res_kind == fxd_pkg::KIND_PLAIN && res_count != 16'd0 |-> prev_valid_q && prev_kind_q == fxd_pkg::KIND_PLAIN && prev_count_q == res_count - 16'd1)
	`FXD_ASSERT(a_end_after_payload, clk, arst_n, acc && (res_kind == fxd_pkg::KIND_GOOD || res_kind == fxd_pkg::KIND_BADEND) |-> prev_valid_q && prev_kind_q == fxd_pkg::KIND_PLAIN && prev_count_q + 16'd1 == res_count)
	`FXD_ASSERT(a_reject_empty, clk, arst_n, acc && res_kind == fxd_pkg::KIND_REJECT |-> res_count == 16'd0 && res_plain == 8'h00)

endmodule

bind framed_xor_stream_decrypter fxd_checker u_fxd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_kind  (res.result_kind),
	.res_plain (res.plain_byte),
	.res_count (res.byte_count)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the framed XOR stream decrypter: random frames in, plaintext and status out.
// Depends on fxd_pkg, the fxd_rx_if / fxd_res_if interfaces and framed_xor_stream_decrypter.
`timescale 1ns / 1ps

module tb_top;
	import fxd_pkg::*;

	// Tracks the frame state of the block and holds the results it owes
	class plaintext_scoreboard;
		typedef struct packed {
			logic [2:0]  kind;
			logic [7:0]  plain;
			logic [15:0] count;
		} outcome_t;

		outcome_t    awaited_results[$];
		int unsigned errors;
		logic [15:0] limit;
		phase_t      ph;
		int unsigned fld;
		logic [7:0]  acc [ACCESS_BYTES];
		logic [31:0] stamp;
		logic [31:0] size;
		logic [7:0]  dkey [KEY_BYTES];
		logic [7:0]  kstream [KEY_BYTES];
		logic [15:0] pidx;

		function new();
			errors = 0;
			limit  = RESET_LIMIT;
			ph     = PH_HUNT;
			fld    = 0;
			stamp  = '0;
			size   = '0;
			pidx   = '0;
		endfunction

		function int unsigned pending();
			return awaited_results.size();
		endfunction

		function void await_result(logic [2:0] kind, logic [7:0] plain, logic [15:0] count);
			outcome_t o;
			o.kind  = kind;
			o.plain = plain;
			o.count = count;
			awaited_results.push_back(o);
		endfunction

		function void note_request(logic act, logic [7:0] b);
			int unsigned i;
			int unsigned j;
			logic [7:0]  ts;
			if (act == ACT_TIMEOUT) begin
				if (ph != PH_HUNT) begin
					ph  = PH_HUNT;
					fld = 0;
					await_result(KIND_TIMEOUT, 8'h00, pidx);
				end
				return;
			end
			case (ph)
				PH_HUNT: begin
					if (b == START_BYTE) begin
						ph    = PH_ACCESS;
						fld   = 0;
						stamp = '0;
						size  = '0;
						pidx  = '0;
					end
				end
				PH_ACCESS: begin
					acc[fld] = b;
					fld = (fld + 1) % ACCESS_BYTES;
					if (fld == 0)
						ph = PH_STAMP;
				end
				PH_STAMP: begin
					stamp = stamp | (32'(b) << (8 * fld));
					fld = (fld + 1) % 4;
					if (fld == 0)
						ph = PH_SIZE;
				end
				PH_SIZE: begin
					size = size | (32'(b) << (8 * fld));
					fld = (fld + 1) % 4;
					if (fld == 0) begin
						if (size == 0 || size > 32'(limit)) begin
							ph = PH_HUNT;
							await_result(KIND_REJECT, 8'h00, 16'h0000);
						end else begin
							for (i = 0; i < KEY_BYTES; i++) begin
								ts = 8'(stamp >> i);
								dkey[i]    = acc[i % ACCESS_BYTES] ^ ts ^ KEY_SALT;
								kstream[i] = dkey[i];
							end
							pidx = '0;
							ph   = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					i = pidx;
					// advance the keystream at every full key length
					if (i > 0 && (i % KEY_BYTES) == 0)
						for (j = 0; j < KEY_BYTES; j++)
							kstream[j] = kstream[j] ^ dkey[j] ^ i[7:0];
					await_result(KIND_PLAIN, b ^ kstream[i % KEY_BYTES], pidx);
					pidx = pidx + 16'd1;
					if (i + 1 >= size)
						ph = PH_END;
				end
				PH_END: begin
					ph = PH_HUNT;
					await_result((b == END_BYTE) ? KIND_GOOD : KIND_BADEND, 8'h00, pidx);
				end
				default: begin
					ph  = PH_HUNT;
					fld = 0;
				end
			endcase
		endfunction

		function void check_result(logic [2:0] kind, logic [7:0] plain, logic [15:0] count);
			outcome_t o;
			if (awaited_results.size() == 0) begin
				$error("result with nothing awaited: kind %0d plain %0h count %0d",
					kind, plain, count);
				errors++;
				return;
			end
			o = awaited_results.pop_front();
			if (kind !== o.kind) begin
				$error("result_kind expected %0d actual %0d", o.kind, kind);
				errors++;
			end
			if (plain !== o.plain) begin
				$error("plain_byte expected %0h actual %0h", o.plain, plain);
				errors++;
			end
			if (count !== o.count) begin
				$error("byte_count expected %0d actual %0d", o.count, count);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        calm;
	logic [15:0] cur_limit;

	plaintext_scoreboard board;

	fxd_rx_if  rx_ch ();
	fxd_res_if res_ch ();

	framed_xor_stream_decrypter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Result side: random back-pressure, none while calm
	always @(negedge clk) begin
		res_ch.ready <= calm || ($urandom_range(0, 99) >= 14);
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			board.check_result(res_ch.result_kind, res_ch.plain_byte, res_ch.byte_count);
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_req(input logic act, input logic [7:0] b);
		if (!calm && $urandom_range(0, 99) < 16) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.action  <= act;
		rx_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (!rx_ch.ready);
		board.note_request(act, b);
		@(negedge clk);
	endtask

	// Hold requests until every owed result has left, then let the pipe settle
	task automatic drain_results();
		rx_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		board.limit = v;
		cur_limit   = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Send one frame; with cut set, a timeout replaces a random byte after the start and ends the frame
	task automatic send_frame(input logic [63:0] key, input logic [31:0] stamp,
		input logic [31:0] size, input logic [7:0] end_b, input bit cut,
		inout int unsigned sent);
		logic [7:0] frame_q[$];
		int         abort_at;
		int         k;
		frame_q.push_back(START_BYTE);
		for (k = 0; k < ACCESS_BYTES; k++)
			frame_q.push_back(key[8*k +: 8]);
		for (k = 0; k < 4; k++)
			frame_q.push_back(stamp[8*k +: 8]);
		for (k = 0; k < 4; k++)
			frame_q.push_back(size[8*k +: 8]);
		if (size != 0 && size <= 32'(cur_limit)) begin
			for (k = 0; k < int'(size); k++)
				frame_q.push_back(8'($urandom_range(0, 255)));
			frame_q.push_back(end_b);
		end
		abort_at = cut ? $urandom_range(1, frame_q.size() - 1) : -1;
		for (k = 0; k < frame_q.size(); k++) begin
			sent++;
			if (k == abort_at) begin
				send_req(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
				return;
			end
			send_req(ACT_BYTE, frame_q[k]);
		end
	endtask

	function automatic logic [31:0] pick_size();
		int unsigned r;
		int unsigned cap;
		if (cur_limit == 0)
			return $urandom_range(1, 40);
		r = $urandom_range(0, 99);
		if (r < 10 && cur_limit <= 400)
			return cur_limit;
		if (r < 80)
			cap = 40;
		else if (r < 96)
			cap = 130;
		else
			cap = 300;
		if (cap > cur_limit)
			cap = cur_limit;
		return $urandom_range(1, cap);
	endfunction

	initial begin
		#2_000_000;
		$display("FAIL framed_xor_stream_decrypter");
		$finish;
	end

	initial begin
		int unsigned phase_items;
		int unsigned sent;
		int unsigned r;
		int unsigned p;
		logic [15:0] limits [6];
		int unsigned budget [6];
		logic [31:0] size;
		logic [7:0]  end_b;
		bit          cut;

		board         = new();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		calm          = 1'b0;
		cur_limit     = RESET_LIMIT;
		rx_ch.valid   = 1'b0;
		rx_ch.action  = ACT_BYTE;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;

		limits = '{RESET_LIMIT, 16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(17, 48)), 16'd16};
		budget = '{180, 150, 60, 30, 130, 100};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: noise and timeout while hunting, early abort, one-byte frame
		sent = 0;
		send_req(ACT_BYTE, 8'hFF);
		send_req(ACT_TIMEOUT, 8'h00);
		send_req(ACT_BYTE, START_BYTE);
		send_req(ACT_BYTE, 8'h00);
		send_req(ACT_TIMEOUT, 8'hFF);
		send_frame(64'hFF00_FF00_00FF_00FF, 32'hFFFF_FFFF, 32'd1, END_BYTE, 1'b0, sent);

		for (p = 0; p < 6; p++) begin
			if (p > 0) begin
				drain_results();
				write_limit(limits[p]);
			end
			calm = (p == 1);
			phase_items = 0;
			while (phase_items < budget[p]) begin
				r     = $urandom_range(0, 99);
				size  = pick_size();
				end_b = END_BYTE;
				cut   = 1'b0;
				if (r < 62) begin
					// well-formed frame
				end else if (r < 70) begin
					do
						end_b = 8'($urandom_range(0, 255));
					while (end_b == END_BYTE);
				end else if (r < 76) begin
					size = 32'd0;
				end else if (r < 82) begin
					if ($urandom_range(0, 1))
						size = 32'(cur_limit) + $urandom_range(1, 3);
					else
						size = $urandom | 32'h0001_0000;
				end else if (r < 90) begin
					cut = 1'b1;
				end else begin
					// line noise, then a timeout to resync
					repeat ($urandom_range(1, 4))
						send_req(ACT_BYTE, 8'($urandom_range(0, 255)));
					send_req(ACT_TIMEOUT, 8'($urandom_range(0, 255)));
					continue;
				end
				send_frame({$urandom, $urandom}, $urandom, size, end_b, cut, phase_items);
				if ($urandom_range(0, 19) == 0)
					drain_results();
			end
		end

		drain_results();
		if (board.errors == 0)
			$display("PASS framed_xor_stream_decrypter");
		else
			$display("FAIL framed_xor_stream_decrypter");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/fxd_pkg.sv
rtl/fxd_stream_if.sv
rtl/fxd_keystream.sv
rtl/framed_xor_stream_decrypter.sv
rtl/fxd_checker.sv
tb/sv/tb_top.sv
